@@ hw/rtl/smk_pkg.sv @@
// Shared types and constants for the supermarket model event step block.
`timescale 1ns / 1ps

package smk_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_WALK,
        ST_TRD,
        ST_UPD
    } state_t;

    typedef enum logic [2:0] {
        WALK_ABOVE,
        WALK_SQUARE,
        WALK_DIFF,
        WALK_PAIR,
        WALK_CENTRAL
    } walk_mode_t;

    localparam logic [1:0] POL_TWO_REPL   = 2'd0;
    localparam logic [1:0] POL_TWO_NOREPL = 2'd1;
    localparam logic [1:0] POL_ONE        = 2'd2;
    localparam logic [1:0] POL_CENTRAL    = 2'd3;

    localparam logic [1:0] KIND_RAND_DEP    = 2'd0;
    localparam logic [1:0] KIND_ARRIVAL     = 2'd1;
    localparam logic [1:0] KIND_CENTRAL_DEP = 2'd2;

    localparam logic [1:0] REG_POLICY    = 2'd0;
    localparam logic [1:0] REG_NUM_Q     = 2'd1;
    localparam logic [1:0] REG_DEP_THR   = 2'd2;
    localparam logic [1:0] REG_CENT_THR  = 2'd3;

    // Per-event products used by the level test.
    typedef struct packed {
        logic [15:0] n;
        logic [47:0] un;
        logic [63:0] unn;
        logic [63:0] rhs;
        logic [31:0] nn;
    } smk_pre_t;

endpackage

@@ hw/rtl/smk_count_mem.sv @@
// Level count memory: one write port, one registered read port.
`timescale 1ns / 1ps

module smk_count_mem #(
    parameter int LEVELS = 64,
    parameter int AW     = 6
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);

    logic [15:0] mem [LEVELS];
    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/smk_level_test.sv @@
// Exact integer test that decides whether the walk advances past one level.
`timescale 1ns / 1ps

module smk_level_test (
    input  smk_pkg::walk_mode_t mode,
    input  smk_pkg::smk_pre_t   pre,
    input  logic [15:0]         cnt,
    output logic                advance
);
    import smk_pkg::*;

    logic [31:0] cc;
    logic [32:0] cc1;
    logic [31:0] diff_x;
    logic [48:0] diff_lhs;
    logic        pair_go;

    always_comb begin
        cc       = 32'(cnt) * 32'(cnt);
        cc1      = {1'b0, cc} + 33'(cnt);
        diff_x   = pre.nn - cc1[31:0];
        diff_lhs = {1'b0, cnt, 32'd0} + {1'b0, pre.un};
        pair_go  = (cc1 > {1'b0, pre.nn})
                 || (diff_x < pre.rhs[63:32])
                 || ((diff_x == pre.rhs[63:32]) && (pre.rhs[31:0] != 32'd0));
        unique case (mode)
            WALK_ABOVE:   advance = pre.un[47:32] < cnt;
            WALK_SQUARE:  advance = pre.unn[63:32] < cc;
            WALK_DIFF:    advance = {1'b0, pre.n, 32'd0} < diff_lhs;
            WALK_PAIR:    advance = pair_go;
            WALK_CENTRAL: advance = cnt != 16'd0;
            default:      advance = 1'b0;
        endcase
    end

endmodule

@@ hw/rtl/supermarket_model_event_step_top.sv @@
// Top level of the supermarket model event step block.
`timescale 1ns / 1ps

// Supermarket model event step.
// Input channel (s_valid/s_ready) takes one event request with three 32-bit
// uniforms; the result channel (m_valid/m_ready) returns one result request
// per event: event kind, walk level, changed flag and the updated count.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_wdata
// with no wait; write them only while the block is idle.
// Steps: products in ST_MUL1, ST_MUL2 and ST_MUL3, then the walk over up to
// LEVELS levels, then ST_TRD reads and ST_UPD writes the target count. The walk
// over the level memory reads one entry per cycle; events are handled one at a
// time because each walk needs the counts the previous event left.
// Reset: the configuration registers take their default values, m_valid drops
// and the level memory is swept to zero, one entry per cycle, with s_ready low.
// Stall: a finished result waits in the output register; the next event is
// accepted and walked meanwhile, and holds in its write-back cycle until the
// output register is free.
module supermarket_model_event_step_top #(
    parameter int LEVELS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_u_event,
    input  logic [31:0] s_u_select,
    input  logic [31:0] s_u_pick,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_kind,
    output logic [6:0]  m_level,
    output logic        m_changed,
    output logic [15:0] m_new_count
);
    import smk_pkg::*;

    localparam int AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int IW = $clog2(LEVELS + 1);
    localparam logic [AW-1:0] LAST = AW'(LEVELS - 1);
    localparam logic [IW-1:0] TOP  = IW'(LEVELS);

    // Configuration registers.
    logic [1:0]  policy_reg;
    logic [15:0] num_q_reg;
    logic [31:0] dep_thr_reg;
    logic [31:0] cent_thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg   <= POL_TWO_REPL;
            num_q_reg    <= 16'd1000;
            dep_thr_reg  <= 32'd2386092942;
            cent_thr_reg <= 32'hFFFF_FFFF;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_POLICY:   policy_reg   <= cfg_wdata[1:0];
                REG_NUM_Q:    num_q_reg    <= cfg_wdata[15:0];
                REG_DEP_THR:  dep_thr_reg  <= cfg_wdata;
                REG_CENT_THR: cent_thr_reg <= cfg_wdata;
                default:      policy_reg   <= policy_reg;
            endcase
        end
    end

    state_t state_reg, state_next;

    // Event context.
    walk_mode_t  mode_reg;
    logic [1:0]  kind_reg;
    logic [31:0] u_reg;
    smk_pre_t    pre_reg;
    logic [AW-1:0] k_reg;
    logic [AW-1:0] clr_reg;
    logic [IW-1:0] lvl_reg;
    logic          has_tgt_reg;
    logic [AW-1:0] tgt_reg;

    // Output register.
    logic        m_valid_reg;
    logic [1:0]  m_kind_reg;
    logic [6:0]  m_level_reg;
    logic        m_changed_reg;
    logic [15:0] m_count_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [15:0]   mem_rdata;
    logic          advance;
    logic          accept;
    logic          out_free;
    logic          walk_done;
    logic [IW-1:0] lvl_fin;
    logic          is_dep;
    logic          is_inc;
    logic          cnt_ok;

    smk_count_mem #(.LEVELS(LEVELS), .AW(AW)) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    smk_level_test u_test (
        .mode    (mode_reg),
        .pre     (pre_reg),
        .cnt     (mem_rdata),
        .advance (advance)
    );

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign is_inc   = (kind_reg == KIND_ARRIVAL);
    assign is_dep   = !is_inc;
    // Saturation: drop a decrement of zero and an increment at N or above.
    assign cnt_ok   = is_inc ? (mem_rdata < pre_reg.n) : (mem_rdata != 16'd0);

    // Walk end: stop at the first failing level, past the last one, or at once for a central walk with N of zero.
    always_comb begin
        walk_done = 1'b0;
        lvl_fin   = TOP;
        if ((mode_reg == WALK_CENTRAL) && (pre_reg.n == 16'd0)) begin
            walk_done = 1'b1;
            lvl_fin   = '0;
        end else if (!advance) begin
            walk_done = 1'b1;
            lvl_fin   = (mode_reg == WALK_CENTRAL) ? IW'(k_reg) + IW'(1) : IW'(k_reg);
        end else if (k_reg == LAST) begin
            walk_done = 1'b1;
            lvl_fin   = TOP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = tgt_reg;
        mem_wdata  = is_inc ? mem_rdata + 16'd1 : mem_rdata - 16'd1;
        mem_raddr  = tgt_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = clr_reg;
                mem_wdata  = 16'd0;
                if (clr_reg == LAST) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) state_next = ST_MUL1;
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_MUL3;
            ST_MUL3: begin
                mem_raddr  = '0;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                mem_raddr = (k_reg == LAST) ? k_reg : k_reg + AW'(1);
                if (walk_done) state_next = ST_TRD;
            end
            ST_TRD: state_next = ST_UPD;
            ST_UPD: begin
                if (out_free) begin
                    mem_we     = has_tgt_reg && cnt_ok;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath: clear counter, decode, products, walk counter, target.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (state_reg == ST_CLEAR) begin
            clr_reg <= clr_reg + AW'(1);
        end
        if (accept) begin
            pre_reg.n <= num_q_reg;
            u_reg     <= s_u_select;
            if (s_u_event < dep_thr_reg) begin
                if ((policy_reg == POL_CENTRAL) && !(s_u_select < cent_thr_reg)) begin
                    kind_reg <= KIND_CENTRAL_DEP;
                    mode_reg <= WALK_CENTRAL;
                end else begin
                    kind_reg <= KIND_RAND_DEP;
                    unique case (policy_reg)
                        POL_TWO_REPL, POL_ONE: mode_reg <= WALK_ABOVE;
                        POL_TWO_NOREPL:        mode_reg <= WALK_DIFF;
                        default: begin
                            mode_reg <= WALK_DIFF;
                            u_reg    <= s_u_pick;
                        end
                    endcase
                end
            end else begin
                kind_reg <= KIND_ARRIVAL;
                unique case (policy_reg)
                    POL_TWO_REPL:   mode_reg <= WALK_SQUARE;
                    POL_TWO_NOREPL: mode_reg <= WALK_PAIR;
                    POL_ONE:        mode_reg <= WALK_ABOVE;
                    default:        mode_reg <= WALK_DIFF;
                endcase
            end
        end
        if (state_reg == ST_MUL1) begin
            pre_reg.un <= 48'(u_reg) * 48'(pre_reg.n);
            pre_reg.nn <= 32'(33'(pre_reg.n) * (33'(pre_reg.n) + 33'd1));
        end
        if (state_reg == ST_MUL2) begin
            pre_reg.unn <= 64'(pre_reg.un) * 64'(pre_reg.n);
        end
        if (state_reg == ST_MUL3) begin
            pre_reg.rhs <= pre_reg.unn - 64'(pre_reg.un);
            k_reg       <= '0;
        end
        if (state_reg == ST_WALK) begin
            if (walk_done) begin
                lvl_reg <= lvl_fin;
                unique case (kind_reg)
                    KIND_ARRIVAL: begin
                        has_tgt_reg <= lvl_fin != TOP;
                        tgt_reg     <= AW'(lvl_fin);
                    end
                    KIND_CENTRAL_DEP: begin
                        has_tgt_reg <= lvl_fin > IW'(1);
                        tgt_reg     <= AW'(lvl_fin - IW'(2));
                    end
                    default: begin
                        has_tgt_reg <= lvl_fin != '0;
                        tgt_reg     <= AW'(lvl_fin - IW'(1));
                    end
                endcase
            end else begin
                k_reg <= k_reg + AW'(1);
            end
        end
    end

    // Output register: load at write-back, release on m_ready.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_UPD) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if ((state_reg == ST_UPD) && out_free) begin
            m_kind_reg    <= kind_reg;
            m_level_reg   <= 7'(lvl_reg);
            m_changed_reg <= has_tgt_reg && cnt_ok;
            if (!has_tgt_reg) begin
                m_count_reg <= 16'd0;
            end else if (cnt_ok) begin
                m_count_reg <= is_dep ? mem_rdata - 16'd1 : mem_rdata + 16'd1;
            end else begin
                m_count_reg <= mem_rdata;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_event_kind = m_kind_reg;
    assign m_level      = m_level_reg;
    assign m_changed    = m_changed_reg;
    assign m_new_count  = m_count_reg;

endmodule
